[rtl/core/pushdown_slot_admission_scheduler_top_macros.svh]
// Assertion macros for the slot admission scheduler checkers.
// Expects clk and rst in the scope where a macro is used.
`ifndef PUSHDOWN_SLOT_ADMISSION_SCHEDULER_TOP_MACROS_SVH
`define PUSHDOWN_SLOT_ADMISSION_SCHEDULER_TOP_MACROS_SVH

// checked only outside reset
`define PSAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define PSAS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/psas_pkg.sv]
// Shared types and constants for the slot admission scheduler.
// No dependencies; imported by every module of the block.
package psas_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;
  localparam int TAG_FIELD_BITS  = 8;
  localparam int TAG_WIDE_BITS   = 16;
  localparam int COST_BITS       = 32;
  localparam int SLOT_BITS       = 8;
  localparam int GRANT_CNT_BITS  = 16;
  localparam int CFG_ADDR_BITS   = 4;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [SLOT_BITS-1:0]      CPU_LIMIT_RST  = 8'd16;
  localparam logic [SLOT_BITS-1:0]      IO_LIMIT_RST   = 8'd16;

  typedef enum logic [1:0] {
    REG_CPU_LIMIT  = 2'd0,
    REG_IO_LIMIT   = 2'd1,
    REG_TAIL_EN    = 2'd2,
    REG_TAIL_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [TAG_FIELD_BITS-1:0] request_tag;
    logic                      double_exec;
    logic [COST_BITS-1:0]      pushdown_cost;
    logic [COST_BITS-1:0]      pullup_cost;
    logic                      finished_on_io;
  } req_item_t;

  typedef struct packed {
    logic                      grant_valid;
    logic [TAG_FIELD_BITS-1:0] grant_tag;
    logic                      grant_on_io;
    logic                      was_queued;
    logic                      queue_overflow;
    logic                      tail_reached;
  } res_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]      cpu_limit;
    logic [SLOT_BITS-1:0]      io_limit;
    logic                      tail_en;
    logic [GRANT_CNT_BITS-1:0] tail_count;
    logic                      arm_write;
    logic                      arm_set;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

[rtl/core/pushdown_slot_admission_scheduler_top.sv]
// Slot admission scheduler for a CPU (pushdown) pool and an IO (pushback) pool.
// Channels: req (arrive/finish event) in, res (grant/queue status) out, both
// valid/stall; an event is taken when valid is high and stall is low.
// Configuration: APB-style port, cpu limit at 0x0, io limit at 0x4, tail
// enable at 0x8, tail count at 0xC; pready is always high. Write only idle.
// Every event yields exactly one res beat.
// Timing: an event is taken in idle and executed in the execute state once
// the output register is free; the queue head entries read at accept are
// registered for execute; the res beat shows the cycle after execute. An event
// is only taken once the last has executed, due to the registered queue read.
// Stall: the res beat holds while res_stall is high; one more event is taken
// and waits in execute until the output register frees, then req stalls.
// Reset (rst, synchronous): queues empty, slot and grant counters zero, tail
// check disarmed, limits back to 16. Queue memories are not cleared.
// Depends on psas_pkg, psas_regs, psas_ctrl and psas_datapath.
module pushdown_slot_admission_scheduler_top #(
  parameter int QUEUE_DEPTH = psas_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = psas_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  psas_pkg::req_item_t                 req,
  output logic                                res_valid,
  input  logic                                res_stall,
  output psas_pkg::res_item_t                 res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psas_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [psas_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [psas_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import psas_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;

  psas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (dp_cmd)
  );

  psas_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (dp_cmd),
    .cfg (cfg),
    .req (req),
    .res (res)
  );

endmodule

[rtl/core/psas_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on psas_pkg for register indexes and the cfg_t bundle.
module psas_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psas_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [psas_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [psas_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output psas_pkg::cfg_t                      cfg
);
  import psas_pkg::*;

  logic [SLOT_BITS-1:0]      cpu_limit;
  logic [SLOT_BITS-1:0]      io_limit;
  logic                      tail_en;
  logic [GRANT_CNT_BITS-1:0] tail_count;
  logic                      wr;
  reg_idx_t                  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_limit  <= CPU_LIMIT_RST;
      io_limit   <= IO_LIMIT_RST;
      tail_en    <= 1'b0;
      tail_count <= '0;
    end else if (wr) begin
      case (idx)
        REG_CPU_LIMIT:  cpu_limit  <= pwdata[SLOT_BITS-1:0];
        REG_IO_LIMIT:   io_limit   <= pwdata[SLOT_BITS-1:0];
        REG_TAIL_EN:    tail_en    <= pwdata[0];
        REG_TAIL_COUNT: tail_count <= pwdata[GRANT_CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CPU_LIMIT:  prdata = CFG_DATA_BITS'(cpu_limit);
      REG_IO_LIMIT:   prdata = CFG_DATA_BITS'(io_limit);
      REG_TAIL_EN:    prdata = CFG_DATA_BITS'(tail_en);
      REG_TAIL_COUNT: prdata = CFG_DATA_BITS'(tail_count);
      default:        prdata = '0;
    endcase
  end

  // arming follows the value being written, not the stored one
  always_comb begin
    cfg.cpu_limit  = cpu_limit;
    cfg.io_limit   = io_limit;
    cfg.tail_en    = tail_en;
    cfg.tail_count = tail_count;
    cfg.arm_write  = wr && (idx == REG_TAIL_COUNT);
    cfg.arm_set    = pwdata[GRANT_CNT_BITS-1:0] != '0;
  end

endmodule

[rtl/core/psas_ctrl.sv]
// Sequencer: accept, execute, and the output beat handshake.
// Depends on psas_pkg for the datapath command bundle.
module psas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              res_valid,
  input  logic              res_stall,
  output psas_pkg::dp_cmd_t cmd
);
  import psas_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && req_valid;
  // execute only once the output register can take the beat
  assign cmd.exec  = (state == ST_EXEC) && (!res_valid || !res_stall);

  always_comb begin
    case (state)
      ST_IDLE: state_next = req_valid ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = cmd.exec ? ST_IDLE : ST_EXEC;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/psas_datapath.sv]
// Wait queues, slot and grant counters, and the admission decision.
// Depends on psas_pkg; driven by psas_ctrl commands and psas_regs config.
module psas_datapath #(
  parameter int QUEUE_DEPTH = psas_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = psas_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  psas_pkg::dp_cmd_t   cmd,
  input  psas_pkg::cfg_t      cfg,
  input  psas_pkg::req_item_t req,
  output psas_pkg::res_item_t res
);
  import psas_pkg::*;

  localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_BITS  = CNT_BITS + 1;

  logic [TAG_BITS-1:0]  reg_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  dbl_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  reg_rd, dbl_rd;
  req_item_t            item;

  logic [ADDR_BITS-1:0] reg_head, dbl_head, reg_head_next, dbl_head_next;
  logic [CNT_BITS-1:0]  reg_count, dbl_count;
  logic [SLOT_BITS-1:0] cpu_used, io_used, cpu_base, io_base;
  logic [GRANT_CNT_BITS-1:0] granted, gc_inc;
  logic                 tail_armed;

  logic [TAG_WIDE_BITS-1:0] tag_wide, gtag_wide;
  logic [TAG_BITS-1:0]  tag_in, g_tag;
  logic [SUM_BITS-1:0]  reg_sum, dbl_sum;
  logic [ADDR_BITS-1:0] reg_wr_addr, dbl_wr_addr;
  logic cpu_free, io_free, reg_empty, dbl_empty, reg_full, dbl_full, pd_first;
  logic grant, g_io, queued, ovf, tail_hit, count_reg;
  logic reg_push, reg_pop, dbl_push, dbl_pop;

  // head entries are read at accept so they are registered for execute
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item   <= req;
      reg_rd <= reg_q[reg_head];
      dbl_rd <= dbl_q[dbl_head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && reg_push) begin
      reg_q[reg_wr_addr] <= tag_in;
    end
    if (cmd.exec && dbl_push) begin
      dbl_q[dbl_wr_addr] <= tag_in;
    end
  end

  assign tag_wide  = TAG_WIDE_BITS'(item.request_tag);
  assign tag_in    = tag_wide[TAG_BITS-1:0];
  assign cpu_free  = cpu_used < cfg.cpu_limit;
  assign io_free   = io_used < cfg.io_limit;
  assign reg_empty = reg_count == '0;
  assign dbl_empty = dbl_count == '0;
  assign reg_full  = reg_count == CNT_BITS'(QUEUE_DEPTH);
  assign dbl_full  = dbl_count == CNT_BITS'(QUEUE_DEPTH);
  assign pd_first  = item.pushdown_cost <= item.pullup_cost;

  // tail = head + count, wrapped once
  always_comb begin
    reg_sum = SUM_BITS'(reg_head) + SUM_BITS'(reg_count);
    dbl_sum = SUM_BITS'(dbl_head) + SUM_BITS'(dbl_count);
    if (reg_sum >= SUM_BITS'(QUEUE_DEPTH)) reg_sum = reg_sum - SUM_BITS'(QUEUE_DEPTH);
    if (dbl_sum >= SUM_BITS'(QUEUE_DEPTH)) dbl_sum = dbl_sum - SUM_BITS'(QUEUE_DEPTH);
    reg_wr_addr = reg_sum[ADDR_BITS-1:0];
    dbl_wr_addr = dbl_sum[ADDR_BITS-1:0];
  end

  always_comb begin
    grant     = 1'b0;
    g_io      = 1'b0;
    g_tag     = '0;
    queued    = 1'b0;
    ovf       = 1'b0;
    count_reg = 1'b0;
    reg_push  = 1'b0;
    reg_pop   = 1'b0;
    dbl_push  = 1'b0;
    dbl_pop   = 1'b0;
    cpu_base  = cpu_used;
    io_base   = io_used;
    case (item.cmd)
      CMD_ARRIVE: begin
        if (!item.double_exec) begin
          if (reg_empty) begin
            if (pd_first ? cpu_free : io_free) begin
              grant = 1'b1;
              g_io  = !pd_first;
            end else if (pd_first ? io_free : cpu_free) begin
              grant = 1'b1;
              g_io  = pd_first;
            end
          end
          if (grant) begin
            g_tag     = tag_in;
            count_reg = 1'b1;
          end else if (!reg_full) begin
            reg_push = 1'b1;
            queued   = 1'b1;
          end else begin
            ovf = 1'b1;
          end
        end else begin
          if (reg_empty && dbl_empty && cpu_free) begin
            grant = 1'b1;
            g_tag = tag_in;
          end else if (!dbl_full) begin
            dbl_push = 1'b1;
            queued   = 1'b1;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        // release saturates at zero
        if (item.finished_on_io) begin
          if (io_used != '0) io_base = io_used - 1'b1;
        end else begin
          if (cpu_used != '0) cpu_base = cpu_used - 1'b1;
        end
        if (!reg_empty) begin
          grant     = 1'b1;
          reg_pop   = 1'b1;
          g_tag     = reg_rd;
          g_io      = item.finished_on_io;
          count_reg = 1'b1;
        end else if (cfg.tail_en && !dbl_empty && (cpu_base < cfg.cpu_limit)) begin
          grant   = 1'b1;
          dbl_pop = 1'b1;
          g_tag   = dbl_rd;
        end
      end
      default: ;
    endcase
  end

  assign gc_inc   = granted + 1'b1;
  assign tail_hit = count_reg && cfg.tail_en && tail_armed && (gc_inc == cfg.tail_count);

  assign reg_head_next = (reg_head == ADDR_BITS'(QUEUE_DEPTH - 1)) ? '0 : reg_head + 1'b1;
  assign dbl_head_next = (dbl_head == ADDR_BITS'(QUEUE_DEPTH - 1)) ? '0 : dbl_head + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_head   <= '0;
      reg_count  <= '0;
      dbl_head   <= '0;
      dbl_count  <= '0;
      cpu_used   <= '0;
      io_used    <= '0;
      granted    <= '0;
      tail_armed <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (reg_pop) reg_head <= reg_head_next;
        if (dbl_pop) dbl_head <= dbl_head_next;
        if (reg_push) begin
          reg_count <= reg_count + 1'b1;
        end else if (reg_pop) begin
          reg_count <= reg_count - 1'b1;
        end
        if (dbl_push) begin
          dbl_count <= dbl_count + 1'b1;
        end else if (dbl_pop) begin
          dbl_count <= dbl_count - 1'b1;
        end
        cpu_used <= cpu_base + SLOT_BITS'(grant && !g_io);
        io_used  <= io_base + SLOT_BITS'(grant && g_io);
        if (count_reg && cfg.tail_en) begin
          granted <= tail_hit ? '0 : gc_inc;
        end
      end
      if (cfg.arm_write) begin
        tail_armed <= cfg.arm_set;
      end else if (cmd.exec && tail_hit) begin
        tail_armed <= 1'b0;
      end
    end
  end

  assign gtag_wide = TAG_WIDE_BITS'(g_tag);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res.grant_valid    <= grant;
      res.grant_tag      <= gtag_wide[TAG_FIELD_BITS-1:0];
      res.grant_on_io    <= g_io;
      res.was_queued     <= queued;
      res.queue_overflow <= ovf;
      res.tail_reached   <= tail_hit;
    end
  end

endmodule

[rtl/core/psas_checker.sv]
// Port-level checks for the slot admission scheduler, bound to the top level.
// Depends on psas_pkg and the assertion macro header.
`include "pushdown_slot_admission_scheduler_top_macros.svh"

module psas_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input psas_pkg::res_item_t res
);
  import psas_pkg::*;

  `PSAS_ASSERT(a_no_grant_zero, (res_valid && !res.grant_valid |-> res.grant_tag == '0 && !res.grant_on_io), "grant fields set without a grant")
  `PSAS_ASSERT(a_outcome_excl, (res_valid |-> !(res.was_queued && res.queue_overflow) && !(res.grant_valid && (res.was_queued || res.queue_overflow))), "conflicting outcome flags")
  `PSAS_ASSERT(a_tail_needs_grant, (res_valid && res.tail_reached |-> res.grant_valid && !res.was_queued), "tail pulse without a grant")
  `PSAS_ASSERT(a_res_hold, (res_valid && res_stall |=> res_valid && $stable(res)), "stalled res beat changed")
  `PSAS_ASSERT_RST(a_reset_clears, (rst |=> !res_valid), "res valid after reset")

endmodule

bind pushdown_slot_admission_scheduler_top psas_checker u_psas_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for pushdown_slot_admission_scheduler_top: directed table, then random
// phases over several slot limits and tail settings, checked beat by beat against a local model.
// Depends on psas_pkg and the scheduler RTL only.
module tb_top;
  import psas_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_LEN  = 140;
  localparam int NPHASE     = 6;

  typedef struct {
    req_item_t ev;
    bit        typed;
    res_item_t want;
  } dir_row_t;

  typedef struct {
    logic [7:0]  cpu;
    logic [7:0]  io;
    logic        en;
    logic [15:0] tail;
    int          arrive_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid, req_stall, res_valid, res_stall;
  req_item_t req;
  res_item_t res;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;

  // tag of the offered beat travels with it, so the scoreboard sees it race-free
  bit        row_typed;
  res_item_t row_want;

  bit hold_long = 1'b0;
  bit calm      = 1'b0;
  int fail_cnt  = 0;

  res_item_t grant_outlook_q[$];

  // scheduler model state
  logic [7:0]  cpu_cap, io_cap, cpu_busy, io_busy;
  logic        tail_en, tail_armed;
  logic [15:0] tail_target, grant_tally;
  logic [7:0]  regq [DEPTH];
  logic [7:0]  dblq [DEPTH];
  logic [3:0]  reg_hd, dbl_hd;
  logic [4:0]  reg_n, dbl_n;

  always #5 clk = ~clk;

  pushdown_slot_admission_scheduler_top i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // occupy a slot; returns the tail pulse for counted grants
  function automatic logic claim_slot(logic on_io, logic regular);
    if (on_io) io_busy = io_busy + 8'd1;
    else cpu_busy = cpu_busy + 8'd1;
    if (!regular || !tail_en) return 1'b0;
    grant_tally = grant_tally + 16'd1;
    if (tail_armed && grant_tally == tail_target) begin
      tail_armed  = 1'b0;
      grant_tally = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_item_t schedule_event(req_item_t ev);
    res_item_t r;
    logic cpu_free, io_free, pd_first;
    logic [3:0] slot_ix;
    r = '0;
    cpu_free = cpu_busy < cpu_cap;
    io_free  = io_busy < io_cap;
    if (ev.cmd == CMD_ARRIVE) begin
      if (!ev.double_exec) begin
        if (reg_n == 0) begin
          pd_first = ev.pushdown_cost <= ev.pullup_cost;
          if (pd_first ? cpu_free : io_free) begin
            r.grant_valid = 1'b1;
            r.grant_on_io = !pd_first;
          end else if (pd_first ? io_free : cpu_free) begin
            r.grant_valid = 1'b1;
            r.grant_on_io = pd_first;
          end
        end
        if (r.grant_valid) begin
          r.grant_tag    = ev.request_tag;
          r.tail_reached = claim_slot(r.grant_on_io, 1'b1);
        end else if (reg_n < DEPTH) begin
          slot_ix = reg_hd + reg_n[3:0];
          regq[slot_ix] = ev.request_tag;
          reg_n = reg_n + 5'd1;
          r.was_queued = 1'b1;
        end else begin
          r.queue_overflow = 1'b1;
        end
      end else begin
        if (reg_n == 0 && dbl_n == 0 && cpu_free) begin
          r.grant_valid = 1'b1;
          r.grant_tag   = ev.request_tag;
          void'(claim_slot(1'b0, 1'b0));
        end else if (dbl_n < DEPTH) begin
          slot_ix = dbl_hd + dbl_n[3:0];
          dblq[slot_ix] = ev.request_tag;
          dbl_n = dbl_n + 5'd1;
          r.was_queued = 1'b1;
        end else begin
          r.queue_overflow = 1'b1;
        end
      end
    end else begin
      // releasing an unused pool leaves its count at zero
      if (ev.finished_on_io) begin
        if (io_busy > 0) io_busy = io_busy - 8'd1;
      end else begin
        if (cpu_busy > 0) cpu_busy = cpu_busy - 8'd1;
      end
      if (reg_n != 0) begin
        // freed path goes to the regular head, limit not consulted
        r.grant_valid  = 1'b1;
        r.grant_tag    = regq[reg_hd];
        reg_hd = reg_hd + 4'd1;
        reg_n  = reg_n - 5'd1;
        r.grant_on_io  = ev.finished_on_io;
        r.tail_reached = claim_slot(ev.finished_on_io, 1'b1);
      end else if (tail_en && dbl_n != 0 && cpu_busy < cpu_cap) begin
        r.grant_valid = 1'b1;
        r.grant_tag   = dblq[dbl_hd];
        dbl_hd = dbl_hd + 4'd1;
        dbl_n  = dbl_n - 5'd1;
        void'(claim_slot(1'b0, 1'b0));
      end
    end
    return r;
  endfunction

  function automatic req_item_t mk_ev(cmd_t c, logic [7:0] tag, logic dbl, logic [31:0] pd,
                                      logic [31:0] pu, logic fio);
    req_item_t ev;
    ev.cmd = c;
    ev.request_tag = tag;
    ev.double_exec = dbl;
    ev.pushdown_cost = pd;
    ev.pullup_cost = pu;
    ev.finished_on_io = fio;
    return ev;
  endfunction

  function automatic res_item_t mk_res(logic gv, logic [7:0] tag, logic io, logic q, logic ov,
                                       logic tl);
    res_item_t r;
    r.grant_valid = gv;
    r.grant_tag = tag;
    r.grant_on_io = io;
    r.was_queued = q;
    r.queue_overflow = ov;
    r.tail_reached = tl;
    return r;
  endfunction

  function automatic req_item_t pick_event(int arrive_pct);
    req_item_t ev;
    ev.request_tag    = 8'($urandom);
    ev.double_exec    = ($urandom_range(0, 3) == 0);
    ev.finished_on_io = 1'($urandom);
    ev.pushdown_cost  = $urandom;
    ev.pullup_cost    = $urandom;
    case ($urandom_range(0, 7))
      0: ev.pullup_cost = ev.pushdown_cost;
      1: ev.pushdown_cost = '0;
      2: ev.pushdown_cost = '1;
      3: ev.pullup_cost = ev.pushdown_cost + 32'd1;
      4: ev.pushdown_cost = ev.pullup_cost + 32'd1;
      default: ;
    endcase
    if ($urandom_range(0, 99) < arrive_pct) begin
      ev.cmd = CMD_ARRIVE;
    end else begin
      ev.cmd = CMD_FINISH;
      // mostly release a pool that is actually busy
      if (cpu_busy == 0 && io_busy != 0) ev.finished_on_io = ($urandom_range(0, 9) != 0);
      else if (io_busy == 0 && cpu_busy != 0) ev.finished_on_io = ($urandom_range(0, 9) == 0);
    end
    return ev;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // back-to-back APB transfer; psel stays up for the next setup, caller releases the bus
  task automatic apb_xfer(logic wr, reg_idx_t idx, logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
  endtask

  task automatic check_reg(reg_idx_t idx, logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    check_field("register readback", want, rd);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_TAIL_EN: mask = 32'h1;
      REG_TAIL_COUNT: mask = 32'hFFFF;
      default: mask = 32'hFF;
    endcase
    check_reg(idx, val & mask);
    case (idx)
      REG_CPU_LIMIT: cpu_cap = val[7:0];
      REG_IO_LIMIT: io_cap = val[7:0];
      REG_TAIL_EN: tail_en = val[0];
      REG_TAIL_COUNT: begin
        tail_target = val[15:0];
        tail_armed  = val[15:0] != 0;
      end
      default: ;
    endcase
  endtask

  task automatic set_config(phase_t p);
    cfg_write(REG_CPU_LIMIT, {24'd0, p.cpu});
    cfg_write(REG_IO_LIMIT, {24'd0, p.io});
    cfg_write(REG_TAIL_EN, {31'd0, p.en});
    cfg_write(REG_TAIL_COUNT, {16'd0, p.tail});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one beat and hold it until taken; valid is left high
  task automatic send_event(req_item_t ev, bit typed, res_item_t want);
    req       <= ev;
    req_valid <= 1'b1;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // step the clock before polling so the scoreboard has logged the last accepted beat
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (grant_outlook_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t dir_tab [18];
    phase_t   phases [NPHASE];
    res_item_t none;
    none = '0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    row_typed <= 1'b0;
    row_want  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    cpu_cap = 8'd16; io_cap = 8'd16; tail_en = 1'b0; tail_target = '0; tail_armed = 1'b0;
    cpu_busy = '0; io_busy = '0; grant_tally = '0;
    reg_hd = '0; reg_n = '0; dbl_hd = '0; dbl_n = '0;

    // directed rows assume one slot per pool, tail armed at three
    dir_tab[0]  = '{mk_ev(CMD_ARRIVE, 8'h00, 0, 32'h0, 32'h0, 0), 1,
                    mk_res(1, 8'h00, 0, 0, 0, 0)};
    dir_tab[1]  = '{mk_ev(CMD_ARRIVE, 8'hFF, 0, 32'hFFFFFFFF, 32'h0, 0), 1,
                    mk_res(1, 8'hFF, 1, 0, 0, 0)};
    dir_tab[2]  = '{mk_ev(CMD_ARRIVE, 8'h55, 0, 32'h1, 32'h1, 0), 1,
                    mk_res(0, 8'h00, 0, 1, 0, 0)};
    dir_tab[3]  = '{mk_ev(CMD_ARRIVE, 8'hAA, 1, 32'h0, 32'h0, 0), 1,
                    mk_res(0, 8'h00, 0, 1, 0, 0)};
    dir_tab[4]  = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 1), 1,
                    mk_res(1, 8'h55, 1, 0, 0, 1)};
    dir_tab[5]  = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 0), 1,
                    mk_res(1, 8'hAA, 0, 0, 0, 0)};
    dir_tab[6]  = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 0), 1, none};
    dir_tab[7]  = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 1), 1, none};
    dir_tab[8]  = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 1), 1, none};
    dir_tab[9]  = '{mk_ev(CMD_FINISH, 8'h3C, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0), 1, none};
    dir_tab[10] = '{mk_ev(CMD_ARRIVE, 8'h3C, 1, 32'hFFFFFFFF, 32'h0, 1), 1,
                    mk_res(1, 8'h3C, 0, 0, 0, 0)};
    dir_tab[11] = '{mk_ev(CMD_ARRIVE, 8'h01, 0, 32'd5, 32'd7, 1), 1,
                    mk_res(1, 8'h01, 1, 0, 0, 0)};
    dir_tab[12] = '{mk_ev(CMD_ARRIVE, 8'h80, 0, 32'h0, 32'hFFFFFFFF, 0), 0, none};
    dir_tab[13] = '{mk_ev(CMD_ARRIVE, 8'h7F, 1, 32'h12345678, 32'h0, 0), 0, none};
    dir_tab[14] = '{mk_ev(CMD_ARRIVE, 8'h02, 0, 32'd2, 32'd1, 0), 0, none};
    dir_tab[15] = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 0), 0, none};
    dir_tab[16] = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 1), 0, none};
    dir_tab[17] = '{mk_ev(CMD_FINISH, 8'h00, 0, 32'h0, 32'h0, 0), 0, none};

    phases[0] = '{8'd1,   8'd1,   1'b1, 16'd5,     55};
    phases[1] = '{8'd255, 8'd255, 1'b1, 16'hFFFF,  60};
    phases[2] = '{8'd0,   8'd3,   1'b1, 16'd1,     55};
    phases[3] = '{8'd4,   8'd0,   1'b0, 16'd0,     60};
    phases[4] = '{8'd2,   8'd5,   1'b1, 16'd7,     50};
    phases[5] = '{8'd3,   8'd2,   1'b1, 16'd2,     55};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_reg(REG_CPU_LIMIT, 32'd16);
    check_reg(REG_IO_LIMIT, 32'd16);
    check_reg(REG_TAIL_EN, 32'd0);
    check_reg(REG_TAIL_COUNT, 32'd0);
    set_config('{8'd1, 8'd1, 1'b1, 16'd3, 0});

    foreach (dir_tab[i]) begin
      send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
      idle_gap();
    end
    drain();

    for (int p = 0; p < NPHASE; p++) begin
      if (p == NPHASE - 1) calm = 1'b1;
      set_config(phases[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 4 && n == 20) hold_long = 1'b1;
        if (p == 0 && n == 70) drain();
        send_event(pick_event(phases[p].arrive_pct), 1'b0, none);
        idle_gap();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request, none once calm
  initial begin : res_side
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        res_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : scoreboard
    res_item_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = schedule_event(req);
        if (row_typed) want = row_want;
        grant_outlook_q = {grant_outlook_q, want};
      end
      if (res_valid && !res_stall) begin
        if (grant_outlook_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected beat, expected none, got %0h", $time, res);
        end else begin
          want = grant_outlook_q[0];
          grant_outlook_q.delete(0);
          check_field("grant_valid", 32'(want.grant_valid), 32'(res.grant_valid));
          check_field("grant_tag", 32'(want.grant_tag), 32'(res.grant_tag));
          check_field("grant_on_io", 32'(want.grant_on_io), 32'(res.grant_on_io));
          check_field("was_queued", 32'(want.was_queued), 32'(res.was_queued));
          check_field("queue_overflow", 32'(want.queue_overflow), 32'(res.queue_overflow));
          check_field("tail_reached", 32'(want.tail_reached), 32'(res.tail_reached));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
